/* rtl/psvm_pkg.sv */
// psvm_pkg: shared constants, codes, voice entry layout and sine rom builder
// for the polyphonic sine voice mixer; depends on nothing
package psvm_pkg;

    localparam int VOICE_COUNT     = 128;
    localparam int VOICE_BITS      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
    localparam int ROM_BITS        = SINE_TABLE_BITS + 1;
    localparam int ACC_BITS        = 17 + VOICE_BITS;

    localparam int NUM_BITS  = 41;
    localparam int DEN_BITS  = 24;
    localparam int QUOT_BITS = 17;
    localparam int CNT_BITS  = $clog2(QUOT_BITS + 1);

    localparam logic [16:0] Q16_FULL    = 17'h10000;
    localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

    localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(32767);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = -ACC_BITS'(32768);

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_TICK     = 2'd2;

    localparam logic [3:0] CFG_BASE_FREQ = 4'd0;
    localparam logic [3:0] CFG_SPACING   = 4'd1;
    localparam logic [3:0] CFG_PPH       = 4'd2;
    localparam logic [3:0] CFG_GAIN      = 4'd3;
    localparam logic [3:0] CFG_ATTACK    = 4'd4;
    localparam logic [3:0] CFG_DECAY     = 4'd5;
    localparam logic [3:0] CFG_SUSTAIN   = 4'd6;
    localparam logic [3:0] CFG_RELEASE   = 4'd7;

    typedef struct packed {
        logic [6:0]  note;
        logic [3:0]  chan;
        logic [31:0] phase;
        logic [23:0] elapsed;
        logic [16:0] level;
    } t_voice_ent;

    typedef logic [14:0] t_sine_rom [0:QUARTER_LEN];

    function automatic t_sine_rom sine_rom_build();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        for (int i = 0; i <= QUARTER_LEN; i++) begin
            x  = 64'(i) << (30 - SINE_TABLE_BITS);
            x2 = (x * x) >> 30;
            t  = 64'd172272;
            t  = 64'd5026997 - ((x2 * t) >> 30);
            t  = 64'd85569306 - ((x2 * t) >> 30);
            t  = 64'd693598670 - ((x2 * t) >> 30);
            t  = 64'd1686629713 - ((x2 * t) >> 30);
            s  = (x * t) >> 30;
            e  = (s * 64'd32767 + 64'd536870912) >> 30;
            rom[i] = (e > 64'd32767) ? 15'h7FFF : e[14:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_rom_build();

endpackage

/* rtl/psvm_div.sv */
// psvm_div: restoring divider, one quotient bit per cycle, for envelope ramps
// depends on psvm_pkg; quotient must fit QUOT_BITS bits
module psvm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [psvm_pkg::NUM_BITS-1:0]  i_num,
    input  logic [psvm_pkg::DEN_BITS-1:0]  i_den,
    output logic                           o_busy,
    output logic [psvm_pkg::QUOT_BITS-1:0] o_quot
);
    import psvm_pkg::*;

    logic [DEN_BITS-1:0]  r_rem;
    logic [DEN_BITS-1:0]  r_den;
    logic [QUOT_BITS-1:0] r_q;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic [DEN_BITS:0]    trial;
    logic                 take;

    always_comb begin
        trial = {r_rem, r_q[QUOT_BITS-1]};
        take  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= i_num[NUM_BITS-1:QUOT_BITS];
            r_q    <= i_num[QUOT_BITS-1:0];
            r_den  <= i_den;
            r_cnt  <= CNT_BITS'(QUOT_BITS);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem  <= take ? DEN_BITS'(trial - {1'b0, r_den}) : trial[DEN_BITS-1:0];
            r_q    <= {r_q[QUOT_BITS-2:0], take};
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_BITS'(1));
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

/* rtl/polyphonic_sine_voice_mixer.sv */
// polyphonic_sine_voice_mixer: voice bank in one synchronous memory, walked
// one voice at a time by a sequencer; depends on psvm_pkg and psvm_div
//
// channel   signals                                    handshake
// input     i_kind i_note_number i_midi_channel        i_valid / o_stall
// output    o_mixed_sample o_clipped                   o_valid / i_stall
// config    i_cfg_index i_cfg_data                     i_cfg_valid / o_cfg_ready
//
// note on: scans voices one at a time and writes the first idle one, if any
// note off: visits every voice and ungates each gated voice whose note matches
// tick: visits every voice; a busy voice on a ramp waits for the
// one-bit-per-cycle envelope divider, not at sustain or end; then it emits
// synchronous reset clears all voices; no clearing pass is needed
// a result waiting under i_stall holds the block only at the next emit
module polyphonic_sine_voice_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [6:0]         i_note_number,
    input  logic [3:0]         i_midi_channel,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mixed_sample,
    output logic               o_clipped,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import psvm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ON, S_ONWR, S_OFF, S_OFFCHK, S_TK, S_T1, S_T2,
        S_T3, S_T4, S_T5, S_TW, S_T6, S_T7, S_EMIT
    } t_state;

    localparam logic [VOICE_BITS-1:0] LAST = VOICE_BITS'(VOICE_COUNT - 1);

    t_state r_state;
    logic [VOICE_BITS-1:0]  r_v;
    logic [6:0]             r_note;
    logic [3:0]             r_chan;
    logic [VOICE_COUNT-1:0] r_busy, r_gate, r_init;

    logic [15:0] r_cfg_base;
    logic [9:0]  r_cfg_spacing;
    logic [23:0] r_cfg_pph, r_cfg_att, r_cfg_dec, r_cfg_rel;
    logic [14:0] r_cfg_gain;
    logic [16:0] r_cfg_sus;

    t_voice_ent r_mem [0:VOICE_COUNT-1];
    t_voice_ent r_rd;
    t_voice_ent n_ent;
    logic       mem_we;

    logic [21:0]          r_freq;
    logic [31:0]          r_step, r_phase;
    logic [14:0]          r_sin;
    logic                 r_neg;
    logic [29:0]          r_sg;
    logic [16:0]          r_env;
    logic                 r_end, r_need_div, r_decay;
    logic [NUM_BITS-1:0]  r_num;
    logic [DEN_BITS-1:0]  r_den;
    logic [15:0]          r_mag;
    logic signed [ACC_BITS-1:0] r_acc;
    logic                 r_oval, r_clip;
    logic signed [15:0]   r_out;

    logic [23:0] att, dec, rel, n, elapsed_next;
    logic [16:0] sus, old_level, level_wr;
    logic [31:0] old_phase;
    logic [24:0] a_plus_d;
    logic [20:0] fp_prod;
    logic [16:0] mul_a;
    logic [23:0] mul_b;
    logic [40:0] mul_p;
    logic [45:0] step_full;
    logic [46:0] mag_full;
    logic [SINE_TABLE_BITS-1:0] ph_idx;
    logic [ROM_BITS-1:0] rom_idx;
    logic signed [ACC_BITS-1:0] mag_s;
    logic        div_start, div_busy;
    logic [QUOT_BITS-1:0] div_quot;
    logic        accept;
    logic        emit_go;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid        = r_oval;
    assign o_mixed_sample = r_out;
    assign o_clipped      = r_clip;
    assign emit_go        = (r_state == S_EMIT) && (!r_oval || !i_stall);

    always_comb begin
        att = (r_cfg_att == '0) ? 24'd1 : r_cfg_att;
        dec = (r_cfg_dec == '0) ? 24'd1 : r_cfg_dec;
        rel = (r_cfg_rel == '0) ? 24'd1 : r_cfg_rel;
        sus = (r_cfg_sus > Q16_FULL) ? Q16_FULL : r_cfg_sus;
        n   = r_rd.elapsed;
        a_plus_d  = {1'b0, att} + {1'b0, dec};
        old_phase = r_init[r_v] ? r_rd.phase : 32'd0;
        old_level = r_init[r_v] ? r_rd.level : 17'd0;
        elapsed_next = (n == ELAPSED_MAX) ? n : n + 24'd1;
        fp_prod   = r_cfg_spacing * {r_rd.chan, r_rd.note};
        step_full = r_freq * r_cfg_pph;
        mag_full  = r_sg * r_env;
        if (r_gate[r_v]) begin
            mul_a = Q16_FULL - sus;
            mul_b = n - att;
        end else begin
            mul_a = old_level;
            mul_b = rel - n;
        end
        mul_p   = mul_a * mul_b;
        ph_idx  = r_phase[29 -: SINE_TABLE_BITS];
        rom_idx = r_phase[30] ? ROM_BITS'(QUARTER_LEN) - {1'b0, ph_idx} : {1'b0, ph_idx};
        mag_s   = $signed(ACC_BITS'(r_mag));
        level_wr = r_gate[r_v] ? r_env : (r_end ? 17'd0 : old_level);
        div_start = (r_state == S_T2) && r_need_div;
    end

    always_comb begin
        mem_we = 1'b0;
        n_ent  = r_rd;
        case (r_state)
            S_ONWR: begin
                mem_we = 1'b1;
                n_ent  = '{note: r_note, chan: r_chan, phase: old_phase,
                           elapsed: 24'd0, level: old_level};
            end
            S_OFFCHK: begin
                mem_we = (r_rd.note == r_note);
                n_ent.elapsed = 24'd0;
            end
            S_T6: begin
                mem_we = 1'b1;
                n_ent.phase   = r_phase;
                n_ent.elapsed = elapsed_next;
                n_ent.level   = level_wr;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_v] <= n_ent;
        end
        r_rd <= r_mem[r_v];
    end

    psvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_v           <= '0;
            r_busy        <= '0;
            r_gate        <= '0;
            r_init        <= '0;
            r_oval        <= 1'b0;
            r_cfg_base    <= 16'd300;
            r_cfg_spacing <= 10'd25;
            r_cfg_pph     <= 24'd5726623;
            r_cfg_gain    <= 15'd1000;
            r_cfg_att     <= 24'd192;
            r_cfg_dec     <= 24'd192;
            r_cfg_sus     <= 17'd65536;
            r_cfg_rel     <= 24'd192;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE_FREQ: r_cfg_base    <= i_cfg_data[15:0];
                    CFG_SPACING:   r_cfg_spacing <= i_cfg_data[9:0];
                    CFG_PPH:       r_cfg_pph     <= i_cfg_data;
                    CFG_GAIN:      r_cfg_gain    <= i_cfg_data[14:0];
                    CFG_ATTACK:    r_cfg_att     <= i_cfg_data;
                    CFG_DECAY:     r_cfg_dec     <= i_cfg_data;
                    CFG_SUSTAIN:   r_cfg_sus     <= i_cfg_data[16:0];
                    CFG_RELEASE:   r_cfg_rel     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (emit_go) begin
                r_oval <= 1'b1;
            end else if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_note <= i_note_number;
                        r_chan <= i_midi_channel;
                        r_v    <= '0;
                        r_acc  <= '0;
                        case (i_kind)
                            KIND_NOTE_ON:  r_state <= S_ON;
                            KIND_NOTE_OFF: r_state <= S_OFF;
                            KIND_TICK:     r_state <= S_TK;
                            default:       r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ON: begin
                    if (!r_busy[r_v]) begin
                        r_state <= S_ONWR;
                    end else if (r_v == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_ONWR: begin
                    r_busy[r_v] <= 1'b1;
                    r_gate[r_v] <= 1'b1;
                    r_init[r_v] <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_OFF: begin
                    if (r_busy[r_v] && r_gate[r_v]) begin
                        r_state <= S_OFFCHK;
                    end else if (r_v == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_OFFCHK: begin
                    if (r_rd.note == r_note) begin
                        r_gate[r_v] <= 1'b0;
                    end
                    if (r_v == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_OFF;
                    end
                end
                S_TK: begin
                    if (r_busy[r_v]) begin
                        r_state <= S_T1;
                    end else if (r_v == LAST) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_v <= r_v + 1'b1;
                    end
                end
                S_T1: begin
                    r_freq     <= 22'(r_cfg_base) + 22'(fp_prod);
                    r_need_div <= 1'b0;
                    r_decay    <= 1'b0;
                    r_end      <= 1'b0;
                    if (r_gate[r_v]) begin
                        if ({1'b0, n} > a_plus_d) begin
                            r_env <= sus;
                        end else if (n > att) begin
                            r_need_div <= 1'b1;
                            r_decay    <= 1'b1;
                            r_num      <= mul_p;
                            r_den      <= dec;
                        end else begin
                            r_need_div <= 1'b1;
                            r_num      <= {1'b0, n, 16'd0};
                            r_den      <= att;
                        end
                    end else begin
                        if (n > rel) begin
                            r_end <= 1'b1;
                            r_env <= 17'd0;
                        end else begin
                            r_need_div <= 1'b1;
                            r_num      <= mul_p;
                            r_den      <= rel;
                        end
                    end
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_step  <= step_full[39:8];
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_phase <= old_phase + r_step;
                    r_state <= S_T4;
                end
                S_T4: begin
                    r_sin   <= SINE_ROM[rom_idx];
                    r_neg   <= r_phase[31];
                    r_state <= S_T5;
                end
                S_T5: begin
                    r_sg    <= r_sin * r_cfg_gain;
                    r_state <= S_TW;
                end
                S_TW: begin
                    if (!r_need_div) begin
                        r_state <= S_T6;
                    end else if (!div_busy) begin
                        r_env   <= r_decay ? Q16_FULL - div_quot : div_quot;
                        r_state <= S_T6;
                    end
                end
                S_T6: begin
                    r_mag <= mag_full[46:31];
                    if (r_end) begin
                        r_busy[r_v] <= 1'b0;
                    end
                    r_state <= S_T7;
                end
                S_T7: begin
                    r_acc <= r_neg ? r_acc - mag_s : r_acc + mag_s;
                    if (r_v == LAST) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_v     <= r_v + 1'b1;
                        r_state <= S_TK;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (r_acc > SAT_HI) begin
                            r_out  <= 16'sh7FFF;
                            r_clip <= 1'b1;
                        end else if (r_acc < SAT_LO) begin
                            r_out  <= 16'sh8000;
                            r_clip <= 1'b1;
                        end else begin
                            r_out  <= r_acc[15:0];
                            r_clip <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_gate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gate & ~r_busy) == '0)
        else $error("gated voice not busy");

    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |-> (o_mixed_sample == 16'sh7FFF ||
                                    o_mixed_sample == 16'sh8000))
        else $error("clipped beat not at a rail");

endmodule
